### hw/rtl/mlc_pkg.sv
package mlc_pkg;

   typedef enum logic [2:0] {
      OUT_HIT       = 3'd0,
      OUT_MISS_NEW  = 3'd1,
      OUT_MISS_VER  = 3'd2,
      OUT_FILLED    = 3'd3,
      OUT_BUSY      = 3'd4,
      OUT_FILL_IGN  = 3'd5
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_OUT
   } state_type;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_FILL   = 1'b1;

   // per-cell control from the sequencer
   typedef struct packed {
      logic hit_wr;     // write incremented/held count to the hit cell
      logic halve;      // shift every count right by two
      logic alloc;      // take new key in the selected cell
      logic ver_wr;     // take new version in the selected cell
      logic fill_wr;    // take fill payload in the selected cell
      logic swap;       // swap the selected cell with the one before it
   } cell_ctl_type;

endpackage

### hw/rtl/mlc_cell.sv
module mlc_cell #(
   parameter int HIT_BITS    = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mlc_pkg::cell_ctl_type    ctl,
   input  logic                     sel,       // this cell is the target
   input  logic                     sel_next,  // the cell after this one is the swap source
   input  logic [HIT_BITS-1:0]      hit_value,
   input  logic [HANDLE_BITS-1:0]   key_type,
   input  logic [HANDLE_BITS-1:0]   key_op,
   input  logic [31:0]              key_ver,
   input  logic [HANDLE_BITS-1:0]   fill_method,
   input  logic [HANDLE_BITS-1:0]   fill_type,
   input  logic [31:0]              fill_offset,
   // neighbor entry (i+1 for swap down into this cell, i-1 for swap up)
   input  logic                     nb_next_valid,
   input  logic [HIT_BITS-1:0]      nb_next_hits,
   input  logic [4*HANDLE_BITS+63:0] nb_next_data,
   input  logic                     nb_prev_valid,
   input  logic [HIT_BITS-1:0]      nb_prev_hits,
   input  logic [4*HANDLE_BITS+63:0] nb_prev_data,
   output logic                     valid,
   output logic [HIT_BITS-1:0]      hits,
   output logic [4*HANDLE_BITS+63:0] data,
   output logic                     match,
   output logic                     ver_eq
);
   import mlc_pkg::*;

   logic                      valid_ff, valid_in;
   logic [HIT_BITS-1:0]       hits_ff, hits_in;
   logic [4*HANDLE_BITS+63:0] data_ff, data_in;

   // data layout: type_key, op_key, version, method, def_type, offset
   localparam int OFF_LO = 0;
   localparam int DT_LO  = 32;
   localparam int ME_LO  = 32 + HANDLE_BITS;
   localparam int VE_LO  = 32 + 2*HANDLE_BITS;
   localparam int OK_LO  = 64 + 2*HANDLE_BITS;
   localparam int TK_LO  = 64 + 3*HANDLE_BITS;

   always_comb begin
      valid_in = valid_ff;
      hits_in  = hits_ff;
      data_in  = data_ff;
      if (ctl.halve) begin
         hits_in = hits_ff >> 2;
      end
      if (ctl.hit_wr && sel) begin
         hits_in = ctl.halve ? (hit_value >> 2) : hit_value;
      end
      if (ctl.alloc && sel) begin
         valid_in = 1'b1;
         hits_in  = HIT_BITS'(1);
         data_in[TK_LO +: HANDLE_BITS] = key_type;
         data_in[OK_LO +: HANDLE_BITS] = key_op;
      end
      if (ctl.ver_wr && sel) begin
         data_in[VE_LO +: 32] = key_ver;
      end
      if (ctl.fill_wr && sel) begin
         data_in[ME_LO +: HANDLE_BITS] = fill_method;
         data_in[DT_LO +: HANDLE_BITS] = fill_type;
         data_in[OFF_LO +: 32]         = fill_offset;
      end
      if (ctl.swap && sel) begin
         valid_in = nb_prev_valid;
         hits_in  = nb_prev_hits;
         data_in  = nb_prev_data;
      end
      if (ctl.swap && sel_next) begin
         valid_in = nb_next_valid;
         hits_in  = nb_next_hits;
         data_in  = nb_next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hits_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         hits_ff  <= hits_in;
      end
      data_ff <= data_in;
   end

   assign valid  = valid_ff;
   assign hits   = hits_ff;
   assign data   = data_ff;
   assign match  = valid_ff && (data_ff[TK_LO +: HANDLE_BITS] == key_type)
                   && (data_ff[OK_LO +: HANDLE_BITS] == key_op);
   assign ver_eq = (data_ff[VE_LO +: 32] == key_ver);

endmodule

### hw/rtl/method_lookup_cache_core.sv
// a lookup hit passes ST_OUT, then a count update in ST_MOVE, then one swap per
// position the entry moves forward; miss and fill go through ST_OUT then ST_MOVE;
// busy and fill-ignored are answered from ST_OUT
// throughput: one transaction at a time, next request taken as the response leaves;
// a response waiting under rsp_stall holds off the next request
// reset clears all valid bits, hit counts and the pending fill
module method_lookup_cache_core #(
   parameter int ENTRIES     = 8,
   parameter int HIT_BITS    = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic [31:0]             req_receiver_type,
   input  logic [31:0]             req_operation,
   input  logic [31:0]             req_op_version,
   input  logic [31:0]             req_fill_method,
   input  logic [31:0]             req_fill_type,
   input  logic [31:0]             req_fill_offset,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mlc_pkg::outcome_type    rsp_outcome,
   output logic [31:0]             rsp_method_out,
   output logic [31:0]             rsp_type_out,
   output logic [31:0]             rsp_offset_out,
   output logic [2:0]              rsp_slot_used
);
   import mlc_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int DW = 4*HANDLE_BITS + 64;
   localparam int HB = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
   localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

   state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic fill_pending_ff, fill_pending_in;
   logic [IW-1:0] pend_ff, pend_in;
   logic [HANDLE_BITS-1:0] kt_ff, ko_ff, fm_ff, ft_ff;
   logic [31:0] kv_ff, fo_ff;
   logic act_ff;
   logic rsp_valid_ff, rsp_valid_in;
   outcome_type out_ff, out_in;
   logic [31:0] m_ff, m_in, t_ff, t_in, o_ff, o_in;
   logic [2:0] slot_ff, slot_in;

   cell_ctl_type ctl;
   logic [ENTRIES-1:0] c_valid, c_match, c_ver, sel, sel_next;
   logic [HIT_BITS-1:0] c_hits [ENTRIES];
   logic [DW-1:0] c_data [ENTRIES];
   logic [HIT_BITS-1:0] hit_value;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         logic nv, pv;
         logic [HIT_BITS-1:0] nh, ph;
         logic [DW-1:0] nd, pd;
         if (g < ENTRIES-1) begin : g_n
            assign nv = c_valid[g+1];
            assign nh = c_hits[g+1];
            assign nd = c_data[g+1];
            assign sel_next[g] = sel[g+1];
         end else begin : g_nl
            assign nv = 1'b0;
            assign nh = '0;
            assign nd = '0;
            assign sel_next[g] = 1'b0;
         end
         if (g > 0) begin : g_p
            assign pv = c_valid[g-1];
            assign ph = c_hits[g-1];
            assign pd = c_data[g-1];
         end else begin : g_pf
            assign pv = 1'b0;
            assign ph = '0;
            assign pd = '0;
         end
         assign sel[g] = (idx_ff == IW'(g));
         mlc_cell #(.HIT_BITS(HIT_BITS), .HANDLE_BITS(HANDLE_BITS)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl), .sel(sel[g]),
            .sel_next(sel_next[g]), .hit_value(hit_value),
            .key_type(kt_ff), .key_op(ko_ff), .key_ver(kv_ff),
            .fill_method(fm_ff), .fill_type(ft_ff), .fill_offset(fo_ff),
            .nb_next_valid(nv), .nb_next_hits(nh), .nb_next_data(nd),
            .nb_prev_valid(pv), .nb_prev_hits(ph), .nb_prev_data(pd),
            .valid(c_valid[g]), .hits(c_hits[g]), .data(c_data[g]),
            .match(c_match[g]), .ver_eq(c_ver[g]));
      end
   endgenerate

   // first stop in search order: first match or first empty, else the last slot
   logic found;
   logic [IW-1:0] stop_idx;
   logic stop_hit;
   always_comb begin
      found = 1'b0;
      stop_idx = IW'(ENTRIES-1);
      stop_hit = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && (c_match[i] || !c_valid[i])) begin
            found = 1'b1;
            stop_idx = IW'(i);
            stop_hit = c_match[i];
         end
      end
   end

   logic [HIT_BITS-1:0] cur_hits, prev_hits;
   assign cur_hits  = c_hits[idx_ff];
   assign prev_hits = (idx_ff != '0) ? c_hits[idx_ff - IW'(1)] : '0;
   assign hit_value = (cur_hits == HIT_MAX) ? HIT_MAX : cur_hits + HIT_BITS'(1);

   logic accept;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         kt_ff  <= HANDLE_BITS'(req_receiver_type[HB-1:0]);
         ko_ff  <= HANDLE_BITS'(req_operation[HB-1:0]);
         kv_ff  <= req_op_version;
         fm_ff  <= HANDLE_BITS'(req_fill_method[HB-1:0]);
         ft_ff  <= HANDLE_BITS'(req_fill_type[HB-1:0]);
         fo_ff  <= req_fill_offset;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      fill_pending_in = fill_pending_ff;
      pend_in = pend_ff;
      ctl = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in = out_ff;
      m_in = m_ff; t_in = t_ff; o_in = o_ff; slot_in = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            m_in = '0; t_in = '0; o_in = '0; slot_in = '0;
            if (act_ff == ACT_FILL) begin
               if (fill_pending_ff) begin
                  idx_in = pend_ff;
                  out_in = OUT_FILLED;
                  slot_in = 3'(pend_ff);
                  fill_pending_in = 1'b0;
                  state_in = ST_MOVE;     // ST_MOVE writes the fill
                  rsp_valid_in = rsp_valid_ff && rsp_stall;
               end else begin
                  out_in = OUT_FILL_IGN;
               end
            end else if (fill_pending_ff) begin
               out_in = OUT_BUSY;
            end else begin
               idx_in = stop_idx;
               slot_in = 3'(stop_idx);
               if (found && stop_hit) begin
                  if (c_ver[stop_idx]) begin
                     out_in = OUT_HIT;
                     m_in = 32'(c_data[stop_idx][32+2*HANDLE_BITS-1 -: HANDLE_BITS]);
                     t_in = 32'(c_data[stop_idx][32+HANDLE_BITS-1 -: HANDLE_BITS]);
                     o_in = c_data[stop_idx][31:0];
                     state_in = ST_MOVE;
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end else begin
                     out_in = OUT_MISS_VER;
                     fill_pending_in = 1'b1;
                     pend_in = stop_idx;
                     state_in = ST_MOVE;
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               end else begin
                  out_in = OUT_MISS_NEW;
                  fill_pending_in = 1'b1;
                  pend_in = stop_idx;
                  state_in = ST_MOVE;
                  rsp_valid_in = rsp_valid_ff && rsp_stall;
               end
            end
         end
         ST_MOVE: begin
            // response register is free here: stall was cleared at accept
            case (out_ff)
               OUT_FILLED: begin
                  ctl.fill_wr = 1'b1;
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
               OUT_MISS_NEW: begin
                  ctl.alloc = 1'b1;
                  ctl.ver_wr = 1'b1;
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
               OUT_MISS_VER: begin
                  ctl.ver_wr = 1'b1;
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
               OUT_HIT: begin
                  ctl.hit_wr = 1'b1;
                  ctl.halve = (cur_hits == HIT_MAX);
                  out_in = OUT_BUSY;   // marks the walk phase
                  state_in = ST_MOVE;
               end
               default: begin
                  // walk: swap forward while count exceeds predecessor's
                  if (idx_ff != '0 && cur_hits > prev_hits) begin
                     ctl.swap = 1'b1;
                     idx_in = idx_ff - IW'(1);
                  end else begin
                     out_in = OUT_HIT;
                     state_in = ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         fill_pending_ff <= 1'b0;
         pend_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         fill_pending_ff <= fill_pending_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
      m_ff <= m_in; t_ff <= t_in; o_ff <= o_in; slot_ff <= slot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_outcome    = out_ff;
   assign rsp_method_out = m_ff;
   assign rsp_type_out   = t_ff;
   assign rsp_offset_out = o_ff;
   assign rsp_slot_used  = slot_ff;

endmodule

### hw/rtl/mlc_checker.sv
module mlc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input mlc_pkg::outcome_type rsp_outcome,
   input logic [31:0]          rsp_method_out,
   input logic [2:0]           rsp_slot_used
);
   import mlc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome))
      else $error("response changed while stalled");

   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken during work");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome != OUT_BUSY || rsp_slot_used == 3'd0)
      else $error("busy response carries a slot");

   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OUT_HIT |-> rsp_method_out == 32'd0)
      else $error("method on non-hit");

endmodule

bind method_lookup_cache_core mlc_checker u_mlc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_outcome(rsp_outcome),
   .rsp_method_out(rsp_method_out), .rsp_slot_used(rsp_slot_used));
